FILE: rtl/signed_binary_to_decimal_ascii_top_defines.svh
// Assertion macros shared by the converter modules.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SBDA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SBDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sbda_pkg.sv
// Package with the shared types and constants of the decimal text converter.
`timescale 1ns / 1ps
package sbda_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int IN_WIDTH = 64;
    localparam int CHAR_WIDTH = 7;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'd45;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_shift;
        logic emit_shift;
        logic emit_sign;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bits_last;
        logic top_zero;
        logic dig_one;
        logic neg;
    } sts_t;

endpackage

FILE: rtl/signed_binary_to_decimal_ascii_top.sv
// After the accepting edge the datapath runs the shift-add-3 conversion over all VALUE_BITS
// bits, then drops leading zero digits and decides on the sign before the first character is offered.
// Dropped zeros and emitted digits always total NDIG, with a minus sign before negative values;
// a new item is accepted only after the final character of the last one is taken, and a low
// m_ready holds the character output.
// Reset (aresetn low, synchronous) returns the controller to idle and drops any item.
`timescale 1ns / 1ps
module signed_binary_to_decimal_ascii_top
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_WIDTH-1:0]   s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_WIDTH-1:0] m_text_char,
    output logic                  m_last_char
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer for one transaction at a time.
    sbda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Conversion datapath.
    sbda_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_value  (s_value),
        .cmd       (cmd),
        .sts       (sts),
        .text_char (m_text_char),
        .last_char (m_last_char)
    );

endmodule

FILE: rtl/sbda_dp.sv
// Datapath: magnitude, bit-serial shift-add-3 BCD conversion and character output.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_top_defines.svh"
module sbda_dp
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_WIDTH-1:0]   in_value,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic [CHAR_WIDTH-1:0] text_char,
    output logic                  last_char
);

    // Enough BCD digits for any VALUE_BITS-bit magnitude (log10(2) ~ 1233/4096).
    localparam int NDIG      = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W     = NDIG * 4;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;

    logic [VALUE_BITS-1:0] raw;
    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;

    assign raw       = in_value[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // Next-state logic for the datapath registers.
    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load) begin
            neg_next     = raw[VALUE_BITS-1];
            mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
            bcd_next     = '0;
            bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
            dig_cnt_next = DIG_CNT_W'(NDIG);
        end else if (cmd.conv_step) begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = mag_reg << 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end else if (cmd.skip_shift || cmd.emit_shift) begin
            bcd_next     = bcd_reg << 4;
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
    end

    // Counters are reset; the payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    // Status toward the controller.
    assign sts.bits_last = (bit_cnt_reg == BIT_CNT_W'(1));
    assign sts.top_zero  = (top_digit == 4'd0);
    assign sts.dig_one   = (dig_cnt_reg == DIG_CNT_W'(1));
    assign sts.neg       = neg_reg;

    // Output character: the sign, or the leading BCD digit as ASCII.
    assign text_char = cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + {3'b000, top_digit});
    assign last_char = !cmd.emit_sign && sts.dig_one;

    `SBDA_ASSERT_NOW(a_digit_is_decimal, aclk, aresetn, cmd.emit_shift, top_digit <= 4'd9, "BCD digit out of range on emit")
    `SBDA_ASSERT_NOW(a_skip_keeps_one, aclk, aresetn, cmd.skip_shift, !sts.dig_one && sts.top_zero, "Zero skip would drop the final digit")
    `SBDA_ASSERT_NEXT(a_load_counts, aclk, aresetn, cmd.load, dig_cnt_reg == DIG_CNT_W'(NDIG) && bit_cnt_reg == BIT_CNT_W'(VALUE_BITS), "Counters not initialized on load")

endmodule

FILE: rtl/sbda_ctrl.sv
// Controller state machine sequencing conversion, zero skip and character output.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_top_defines.svh"
module sbda_ctrl
    import sbda_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (sts.bits_last) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (sts.top_zero && !sts.dig_one) begin
                    cmd.skip_shift = 1'b1;
                end else if (sts.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DIGITS;
                end
            end
            ST_SIGN: begin
                m_valid       = 1'b1;
                cmd.emit_sign = 1'b1;
                if (m_ready) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.emit_shift = 1'b1;
                    if (sts.dig_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SBDA_ASSERT_NOW(a_one_side_active, aclk, aresetn, s_ready, !m_valid, "Input and output active together")
    `SBDA_ASSERT_NEXT(a_accept_starts_conv, aclk, aresetn, s_valid && s_ready, state_reg == ST_CONV, "Accepted transaction did not start conversion")
    `SBDA_ASSERT_NEXT(a_last_returns_idle, aclk, aresetn, m_valid && m_ready && !cmd.emit_sign && sts.dig_one, state_reg == ST_IDLE, "Final character did not end the item")

endmodule
